### rtl/core/kuf_pkg.sv
// kuf_pkg: field widths and default sizes shared by the union-find step block
package kuf_pkg;

  localparam int NODE_W = 10;
  localparam int WEIGHT_W = 30;
  localparam int TOTAL_W = 40;
  localparam int NODE_COUNT_DEF = 1024;

endpackage

### rtl/core/kuf_ram.sv
// kuf_ram: generic single-write, single-read RAM with registered read data
module kuf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/kruskal_union_find_step_top.sv
// kruskal_union_find_step_top: one spanning-tree edge per beat on a union-find parent table
//
// Each input beat is an edge (node_a, node_b, edge_weight). The block finds the
// root of each end by path halving over a parent table held in a single-port-read
// RAM, links the first root under the second when they differ, adds the weight to
// a 40-bit running total and returns one result beat (taken, tree_weight). Every
// halving step reads a parent and then a grandparent, each through the RAM's
// registered read port; the input stalls from acceptance of an edge until both
// root searches and the link are done and the result is handed to the output
// register. An edge with an end not below NODE_COUNT is skipped without touching
// the table. After reset the block sweeps the table, one entry a cycle, before
// it accepts the first edge. A finished result waits in the output register
// while the next edge is worked on.
module kruskal_union_find_step_top #(
  parameter int NODE_COUNT = kuf_pkg::NODE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [kuf_pkg::NODE_W-1:0]   in_node_a,
  input  logic [kuf_pkg::NODE_W-1:0]   in_node_b,
  input  logic [kuf_pkg::WEIGHT_W-1:0] in_edge_weight,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_taken,
  output logic [kuf_pkg::TOTAL_W-1:0]  out_tree_weight
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int NW = kuf_pkg::NODE_W;
  localparam int CMP_W = NW + IDX_W + 1;
  localparam logic [CMP_W-1:0] NODE_LIMIT = CMP_W'(NODE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PAR,
    S_GRAND,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [IDX_W-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]              cur_r, cur_nxt;
  logic [IDX_W-1:0]              ra_r, ra_nxt;
  logic [IDX_W-1:0]              nb_r, nb_nxt;
  logic                          phase_b_r, phase_b_nxt;
  logic                          taken_r, taken_nxt;
  logic [kuf_pkg::WEIGHT_W-1:0]  weight_r, weight_nxt;
  logic [kuf_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_taken_r, out_taken_nxt;
  logic [kuf_pkg::TOTAL_W-1:0]   out_tree_weight_r, out_tree_weight_nxt;

  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [IDX_W-1:0]              wr_data;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              rd_data;

  logic [CMP_W-2:0]              a_wide;
  logic [CMP_W-2:0]              b_wide;
  logic [IDX_W-1:0]              a_idx;
  logic [IDX_W-1:0]              b_idx;
  logic                          both_in_range;

  assign a_wide = {{IDX_W{1'b0}}, in_node_a};
  assign b_wide = {{IDX_W{1'b0}}, in_node_b};
  assign a_idx = a_wide[IDX_W-1:0];
  assign b_idx = b_wide[IDX_W-1:0];
  assign both_in_range = ({1'b0, a_wide} < NODE_LIMIT) && ({1'b0, b_wide} < NODE_LIMIT);

  kuf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NODE_COUNT)
  ) u_parent_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cur_nxt = cur_r;
    ra_nxt = ra_r;
    nb_nxt = nb_r;
    phase_b_nxt = phase_b_r;
    taken_nxt = taken_r;
    weight_nxt = weight_r;
    total_nxt = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_taken_nxt = out_taken_r;
    out_tree_weight_nxt = out_tree_weight_r;
    wr_en = 1'b0;
    wr_addr = cur_r;
    wr_data = rd_data;
    rd_addr = cur_r;

    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = a_idx;
        if (in_valid) begin
          cur_nxt = a_idx;
          nb_nxt = b_idx;
          weight_nxt = in_edge_weight;
          phase_b_nxt = 1'b0;
          taken_nxt = 1'b0;
          state_nxt = both_in_range ? S_PAR : S_DONE;
        end
      end
      S_PAR: begin
        if (rd_data == cur_r) begin
          if (!phase_b_r) begin
            ra_nxt = cur_r;
            cur_nxt = nb_r;
            rd_addr = nb_r;
            phase_b_nxt = 1'b1;
          end else begin
            // roots differ: link first root under second
            if (ra_r != cur_r) begin
              wr_en = 1'b1;
              wr_addr = ra_r;
              wr_data = cur_r;
              total_nxt = total_r + {{(kuf_pkg::TOTAL_W - kuf_pkg::WEIGHT_W){1'b0}}, weight_r};
              taken_nxt = 1'b1;
            end else begin
              taken_nxt = 1'b0;
            end
            state_nxt = S_DONE;
          end
        end else begin
          rd_addr = rd_data;
          state_nxt = S_GRAND;
        end
      end
      S_GRAND: begin
        // point current entry at its grandparent and step there
        wr_en = 1'b1;
        wr_addr = cur_r;
        wr_data = rd_data;
        cur_nxt = rd_data;
        rd_addr = rd_data;
        state_nxt = S_PAR;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_taken_nxt = taken_r;
          out_tree_weight_nxt = total_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_cnt_r <= '0;
      total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      total_r <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    ra_r <= ra_nxt;
    nb_r <= nb_nxt;
    phase_b_r <= phase_b_nxt;
    taken_r <= taken_nxt;
    weight_r <= weight_nxt;
    out_taken_r <= out_taken_nxt;
    out_tree_weight_r <= out_tree_weight_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_taken = out_taken_r;
  assign out_tree_weight = out_tree_weight_r;

endmodule
